// ===== rtl/mrirm_pkg.sv =====
// Package for the Modbus read-input-register master.
// Holds the shared types, protocol constants and the CRC-16 byte update.
// No dependencies.
package mrirm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] TICKS_SATURATED = 16'hFFFF;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  QUANTITY_HI     = 8'h00;
    localparam logic [7:0]  QUANTITY_LO     = 8'h01;
    localparam logic [2:0]  RESP_LEN        = 3'd7;

    // Request types.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result kinds.
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Report status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    // Positions in the received response.
    localparam logic [2:0] RX_ADDR     = 3'd0;
    localparam logic [2:0] RX_FUNC     = 3'd1;
    localparam logic [2:0] RX_VALUE_HI = 3'd3;
    localparam logic [2:0] RX_VALUE_LO = 3'd4;

    // Positions in the transmitted query frame.
    localparam logic [2:0] TX_ADDR     = 3'd0;
    localparam logic [2:0] TX_FUNC     = 3'd1;
    localparam logic [2:0] TX_REG_HI   = 3'd2;
    localparam logic [2:0] TX_REG_LO   = 3'd3;
    localparam logic [2:0] TX_QTY_HI   = 3'd4;
    localparam logic [2:0] TX_QTY_LO   = 3'd5;
    localparam logic [2:0] TX_CRC_LO   = 3'd6;
    localparam logic [2:0] TX_CRC_HI   = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // Work handed from the front end to the back end.
    typedef struct packed {
        logic        is_report;
        logic [7:0]  slave;
        logic [15:0] reg_addr;
        logic [15:0] value;
        logic [1:0]  status;
    } cmd_t;

    // One byte through the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/mrirm_front.sv =====
// Front end of the Modbus read-input-register master: accepts requests,
// tracks the exchange state and queues frame or report commands.
// Depends on mrirm_pkg.
module mrirm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 accept,
    input  logic [1:0]           req_type,
    input  logic [7:0]           slave_address,
    input  logic [15:0]          register_address,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output mrirm_pkg::cmd_t      push_cmd
);
    import mrirm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  expected_slave_reg, expected_slave_next;
    logic [2:0]  received_count_reg, received_count_next;
    logic        header_mismatch_reg, header_mismatch_next;
    logic [15:0] captured_value_reg, captured_value_next;
    logic [15:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic [15:0] timeout_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            expected_slave_reg  <= '0;
            received_count_reg  <= '0;
            header_mismatch_reg <= 1'b0;
            captured_value_reg  <= '0;
            elapsed_ticks_reg   <= '0;
            timeout_ticks_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            phase_reg           <= phase_next;
            expected_slave_reg  <= expected_slave_next;
            received_count_reg  <= received_count_next;
            header_mismatch_reg <= header_mismatch_next;
            captured_value_reg  <= captured_value_next;
            elapsed_ticks_reg   <= elapsed_ticks_next;
            if (cfg_we)
                timeout_ticks_reg <= cfg_data;
        end
    end

    always_comb
    begin
        phase_next           = phase_reg;
        expected_slave_next  = expected_slave_reg;
        received_count_next  = received_count_reg;
        header_mismatch_next = header_mismatch_reg;
        captured_value_next  = captured_value_reg;
        elapsed_ticks_next   = elapsed_ticks_reg;
        push                 = 1'b0;
        push_cmd             = '0;

        if (accept)
        begin
            unique case (req_type)
                REQ_START:
                begin
                    // A new request always restarts the exchange.
                    phase_next           = PH_WAIT;
                    expected_slave_next  = slave_address;
                    received_count_next  = '0;
                    header_mismatch_next = 1'b0;
                    captured_value_next  = '0;
                    elapsed_ticks_next   = '0;
                    push                 = 1'b1;
                    push_cmd.is_report   = 1'b0;
                    push_cmd.slave       = slave_address;
                    push_cmd.reg_addr    = register_address;
                end
                REQ_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        priority if (received_count_reg == RX_ADDR &&
                                     rx_byte != expected_slave_reg)
                            header_mismatch_next = 1'b1;
                        else if (received_count_reg == RX_FUNC &&
                                 rx_byte != FUNC_READ_INPUT)
                            header_mismatch_next = 1'b1;
                        else if (received_count_reg == RX_VALUE_HI)
                            captured_value_next = {rx_byte, captured_value_reg[7:0]};
                        else if (received_count_reg == RX_VALUE_LO)
                            captured_value_next = {captured_value_reg[15:8], rx_byte};
                        else
                            captured_value_next = captured_value_reg;

                        received_count_next = received_count_reg + 3'd1;
                        if (received_count_next == RESP_LEN)
                        begin
                            phase_next         = PH_DONE;
                            push               = 1'b1;
                            push_cmd.is_report = 1'b1;
                            if (header_mismatch_next)
                                push_cmd.status = STATUS_MISMATCH;
                            else
                            begin
                                push_cmd.status = STATUS_OK;
                                push_cmd.value  = captured_value_next;
                            end
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (elapsed_ticks_reg != TICKS_SATURATED)
                            elapsed_ticks_next = elapsed_ticks_reg + 16'd1;
                        if (elapsed_ticks_next >= timeout_ticks_reg)
                        begin
                            phase_next         = PH_DONE;
                            push               = 1'b1;
                            push_cmd.is_report = 1'b1;
                            push_cmd.status    = STATUS_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    // Unused request type: no effect.
                end
            endcase
        end
    end

endmodule

// ===== rtl/mrirm_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on mrirm_pkg for the command type.
module mrirm_queue #(
    parameter int DEPTH = mrirm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrirm_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mrirm_pkg::cmd_t   head_cmd
);
    import mrirm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/mrirm_back.sv =====
// Back end of the Modbus read-input-register master: expands queued
// commands into frame bytes with a running CRC, or a single report.
// Depends on mrirm_pkg.
module mrirm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mrirm_pkg::cmd_t     head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [7:0]          tx_byte,
    output logic signed [15:0]  value_tenths,
    output logic [1:0]          status,
    output logic                last
);
    import mrirm_pkg::*;

    cmd_t        cmd_reg;
    logic        active_reg, active_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;

    logic               out_valid_reg;
    logic               kind_reg, kind_next;
    logic [7:0]         tx_reg, tx_next;
    logic signed [15:0] value_reg, value_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    logic load, emit, cmd_done, take;

    assign load     = !out_valid_reg || !out_stall;
    assign emit     = active_reg && load;
    assign cmd_done = cmd_reg.is_report || (idx_reg == TX_CRC_HI);
    assign take     = head_valid && (!active_reg || (emit && cmd_done));
    assign pop      = take;

    always_comb
    begin
        kind_next   = KIND_TX;
        tx_next     = '0;
        value_next  = '0;
        status_next = STATUS_OK;
        last_next   = cmd_done;
        if (cmd_reg.is_report)
        begin
            kind_next   = KIND_REPORT;
            value_next  = $signed(cmd_reg.value);
            status_next = cmd_reg.status;
        end
        else
        begin
            unique case (idx_reg)
                TX_ADDR:   tx_next = cmd_reg.slave;
                TX_FUNC:   tx_next = FUNC_READ_INPUT;
                TX_REG_HI: tx_next = cmd_reg.reg_addr[15:8];
                TX_REG_LO: tx_next = cmd_reg.reg_addr[7:0];
                TX_QTY_HI: tx_next = QUANTITY_HI;
                TX_QTY_LO: tx_next = QUANTITY_LO;
                TX_CRC_LO: tx_next = crc_reg[7:0];
                TX_CRC_HI: tx_next = crc_reg[15:8];
                default:   tx_next = '0;
            endcase
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (take)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            crc_next    = CRC_INIT;
        end
        else if (emit && cmd_done)
            active_next = 1'b0;
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
            // The checksum covers the six header bytes only.
            if (idx_reg < TX_CRC_LO)
                crc_next = crc_byte(crc_reg, tx_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            if (load)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (take)
            cmd_reg <= head_cmd;
        if (emit)
        begin
            kind_reg   <= kind_next;
            tx_reg     <= tx_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign tx_byte      = tx_reg;
    assign value_tenths = value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/modbus_read_input_register_master_top.sv =====
// Top level of the Modbus read-input-register master.
// Instantiates mrirm_front, mrirm_queue and mrirm_back; depends on mrirm_pkg.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  req_type, slave_address, register_address, rx_byte
//   out      out_valid/ out_stall result_kind, tx_byte, value_tenths, status, last
//   cfg      cfg_we               cfg_data (timeout_ticks)
//
// An input transaction is accepted in any cycle the command queue has room;
// its state update completes in that cycle. A start request yields eight
// output transactions, one per unstalled cycle, set by the byte sequencer in
// the back end; a report yields one. Only start requests and reports use the
// queue. Reset clears the exchange state and loads timeout_ticks with 200. A
// stalled output holds its payload; the queue lets input continue meanwhile.
module modbus_read_input_register_master_top #(
    parameter int QUEUE_DEPTH = mrirm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [7:0]         slave_address,
    input  logic [15:0]        register_address,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [7:0]         tx_byte,
    output logic signed [15:0] value_tenths,
    output logic [1:0]         status,
    output logic               last
);
    import mrirm_pkg::*;

    logic  q_full, q_push, q_pop, q_valid;
    cmd_t  q_push_cmd, q_head_cmd;

    assign in_stall = q_full;

    mrirm_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .accept           (in_valid && !q_full),
        .req_type         (req_type),
        .slave_address    (slave_address),
        .register_address (register_address),
        .rx_byte          (rx_byte),
        .push             (q_push),
        .push_cmd         (q_push_cmd)
    );

    mrirm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    mrirm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_cmd     (q_head_cmd),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .tx_byte      (tx_byte),
        .value_tenths (value_tenths),
        .status       (status),
        .last         (last)
    );

endmodule

// ===== tb/tb_modbus_read_input_register_master_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modbus_read_input_register_master_top.
// Drives query requests, response bytes and ticks and checks every result
// against an in-bench model of the client; depends on mrirm_pkg and the RTL.
module tb_modbus_read_input_register_master_top;
    import mrirm_pkg::*;

    localparam logic [1:0] REQ_UNUSED      = 2'd3;
    localparam int         NO_FIXED        = -1;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         PHASE_ITEMS     = 13;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  slave;
        logic [15:0] register_addr;
        logic [7:0]  rx;
    } req_t;

    typedef struct {
        logic               kind;
        logic [7:0]         tx;
        logic signed [15:0] value;
        logic [1:0]         status;
        logic               is_last;
    } result_t;

    // A directed row: fixed_n is NO_FIXED when the expectation comes from
    // the model, otherwise the typed-in number of reports (0 or 1).
    typedef struct {
        req_t               rq;
        int                 fixed_n;
        logic [1:0]         fixed_status;
        logic signed [15:0] fixed_value;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic [7:0]         slave_address;
    logic [15:0]        register_address;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic [7:0]         tx_byte;
    logic signed [15:0] value_tenths;
    logic [1:0]         status;
    logic               last;

    // Model of the client.
    phase_t      model_phase;
    logic [7:0]  model_slave;
    logic [2:0]  model_count;
    logic        model_bad_header;
    logic [15:0] model_value;
    logic [15:0] model_ticks;
    logic [15:0] model_timeout;

    result_t pending_results[$];
    row_t    directed_rows[$];

    bit burst_mode;
    bit hold_off_req;
    bit hold_active;
    int fail_count;
    int items_sent;
    int frames_sent;
    int settings_used;
    int reports_ok;
    int reports_mismatch;
    int reports_timeout;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    modbus_read_input_register_master_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .slave_address    (slave_address),
        .register_address (register_address),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .tx_byte          (tx_byte),
        .value_tenths     (value_tenths),
        .status           (status),
        .last             (last)
    );

    function automatic logic [15:0] query_crc(input logic [47:0] hdr);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            acc = acc ^ {8'h00, hdr[47 - 8 * i -: 8]};
            for (int b = 0; b < 8; b++)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic int idle_len();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] slave,
                                      input logic [15:0] register_addr, input logic [7:0] rx);
        req_t rq;
        rq.kind          = kind;
        rq.slave         = slave;
        rq.register_addr = register_addr;
        rq.rx            = rx;
        return rq;
    endfunction

    task automatic reset_model();
        model_phase      = PH_IDLE;
        model_slave      = 8'h00;
        model_count      = 3'd0;
        model_bad_header = 1'b0;
        model_value      = 16'h0000;
        model_ticks      = 16'h0000;
        model_timeout    = TIMEOUT_RESET;
    endtask

    task automatic push_result(input logic kind, input logic [7:0] tx,
                               input logic signed [15:0] value, input logic [1:0] st,
                               input logic is_last);
        result_t r;
        r.kind    = kind;
        r.tx      = tx;
        r.value   = value;
        r.status  = st;
        r.is_last = is_last;
        pending_results.push_back(r);
    endtask

    // Advances the model by one request; queues its results when enqueue is set.
    task automatic apply_request(input req_t rq, input bit enqueue);
        logic [47:0] hdr;
        logic [15:0] crc;
        logic [63:0] frame;
        case (rq.kind)
            REQ_START:
            begin
                hdr   = {rq.slave, FUNC_READ_INPUT, rq.register_addr, QUANTITY_HI, QUANTITY_LO};
                crc   = query_crc(hdr);
                frame = {hdr, crc[7:0], crc[15:8]};
                if (enqueue)
                    for (int i = 0; i < 8; i++)
                        push_result(KIND_TX, frame[63 - 8 * i -: 8], 16'sd0, STATUS_OK, i == 7);
                model_phase      = PH_WAIT;
                model_slave      = rq.slave;
                model_count      = 3'd0;
                model_bad_header = 1'b0;
                model_value      = 16'h0000;
                model_ticks      = 16'h0000;
            end
            REQ_BYTE:
            begin
                if (model_phase == PH_WAIT)
                begin
                    if (model_count == RX_ADDR && rq.rx != model_slave)
                        model_bad_header = 1'b1;
                    else if (model_count == RX_FUNC && rq.rx != FUNC_READ_INPUT)
                        model_bad_header = 1'b1;
                    else if (model_count == RX_VALUE_HI)
                        model_value[15:8] = rq.rx;
                    else if (model_count == RX_VALUE_LO)
                        model_value[7:0] = rq.rx;
                    model_count = model_count + 3'd1;
                    if (model_count >= RESP_LEN)
                    begin
                        model_phase = PH_DONE;
                        if (enqueue && model_bad_header)
                            push_result(KIND_REPORT, 8'h00, 16'sd0, STATUS_MISMATCH, 1'b1);
                        else if (enqueue)
                            push_result(KIND_REPORT, 8'h00, model_value, STATUS_OK, 1'b1);
                    end
                end
            end
            REQ_TICK:
            begin
                if (model_phase == PH_WAIT)
                begin
                    if (model_ticks != TICKS_SATURATED)
                        model_ticks = model_ticks + 16'd1;
                    if (model_ticks >= model_timeout)
                    begin
                        model_phase = PH_DONE;
                        if (enqueue)
                            push_result(KIND_REPORT, 8'h00, 16'sd0, STATUS_TIMEOUT, 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one input transaction, waits for it to be taken, then records
    // what it should produce. in_valid stays high so a following call can
    // present the next payload without a bubble.
    task automatic issue(input req_t rq, input int fixed_n, input logic [1:0] fixed_status,
                         input logic signed [15:0] fixed_value);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        req_type         <= rq.kind;
        slave_address    <= rq.slave;
        register_address <= rq.register_addr;
        rx_byte          <= rq.rx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (rq.kind == REQ_START)
            frames_sent++;
        if (fixed_n == NO_FIXED)
            apply_request(rq, 1'b1);
        else
        begin
            apply_request(rq, 1'b0);
            if (fixed_n == 1)
                push_result(KIND_REPORT, 8'h00, fixed_value, fixed_status, 1'b1);
        end
    endtask

    task automatic send_start(input logic [7:0] slave, input logic [15:0] register_addr);
        issue(make_req(REQ_START, slave, register_addr, 8'($urandom)), NO_FIXED,
              STATUS_OK, 16'sd0);
    endtask

    task automatic send_byte(input logic [7:0] b);
        issue(make_req(REQ_BYTE, 8'($urandom), 16'($urandom), b), NO_FIXED, STATUS_OK, 16'sd0);
    endtask

    task automatic send_tick();
        issue(make_req(REQ_TICK, 8'($urandom), 16'($urandom), 8'($urandom)), NO_FIXED,
              STATUS_OK, 16'sd0);
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [7:0] slave,
                           input logic [15:0] register_addr, input logic [7:0] rx,
                           input int fixed_n, input logic [1:0] fixed_status,
                           input logic signed [15:0] fixed_value);
        row_t row;
        row.rq           = make_req(kind, slave, register_addr, rx);
        row.fixed_n      = fixed_n;
        row.fixed_status = fixed_status;
        row.fixed_value  = fixed_value;
        directed_rows.push_back(row);
    endtask

    // Drops valid, waits until every expected result is out, then lets the
    // block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        cfg_we   <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_we        <= 1'b0;
        model_timeout  = ticks;
        settings_used++;
    endtask

    // One query followed by a response that is mostly well formed; some headers
    // are corrupted, some responses cut short, timing out when timeout <= 16.
    task automatic run_exchange();
        logic [7:0]  addr;
        logic [15:0] regaddr;
        logic [7:0]  rsp [7];
        int          pick;
        int          n_bytes;
        int          n_ticks;
        addr    = 8'($urandom);
        regaddr = 16'($urandom);
        send_start(addr, regaddr);
        for (int i = 0; i < 7; i++)
            rsp[i] = 8'($urandom);
        rsp[RX_ADDR] = addr;
        rsp[RX_FUNC] = FUNC_READ_INPUT;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            rsp[RX_ADDR] = addr ^ (8'h01 << $urandom_range(0, 7));
        else if (pick < 20)
            rsp[RX_FUNC] = FUNC_READ_INPUT ^ (8'h01 << $urandom_range(0, 7));
        n_bytes = ($urandom_range(0, 99) < 80) ? 7 : $urandom_range(0, 6);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_tick();
            send_byte(rsp[i]);
        end
        if (n_bytes < 7)
        begin
            n_ticks = (model_timeout <= 16'd16) ? int'(model_timeout) + 1 : 2;
            for (int i = 0; i < n_ticks; i++)
                send_tick();
        end
        if ($urandom_range(0, 4) == 0)
            send_byte(8'($urandom));
        if ($urandom_range(0, 9) == 0)
            issue(make_req(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                           8'($urandom)), NO_FIXED, STATUS_OK, 16'sd0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_kind == KIND_REPORT)
            begin
                if (status == STATUS_OK)
                    reports_ok++;
                else if (status == STATUS_MISMATCH)
                    reports_mismatch++;
                else
                    reports_timeout++;
            end
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d tx %0d",
                         $time, result_kind, tx_byte);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("tx_byte", want.tx, tx_byte);
                check_field("value_tenths", want.value, value_tenths);
                check_field("status", want.status, status);
                check_field("last", want.is_last, last);
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver side: random stall runs, plus one long hold-off on request.
    initial
    begin
        int n;
        out_stall   = 1'b0;
        hold_active = 1'b0;
        wait (rst_n);
        forever
        begin
            n = 0;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                n            = HOLD_OFF_CYCLES;
            end
            else
                n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                hold_active = 1'b0;
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        logic [15:0] timeout_plan [6];
        int          phase_start;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = 16'h0000;
        in_valid         = 1'b0;
        req_type         = REQ_START;
        slave_address    = 8'h00;
        register_address = 16'h0000;
        rx_byte          = 8'h00;
        burst_mode       = 1'b0;
        hold_off_req     = 1'b0;
        fail_count       = 0;
        items_sent       = 0;
        frames_sent      = 0;
        settings_used    = 0;
        reports_ok       = 0;
        reports_mismatch = 0;
        reports_timeout  = 0;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing is pending after reset, so stray items give no result.
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h55, 0, STATUS_OK, 16'sd0);
        add_row(REQ_TICK, 8'h00, 16'h0000, 8'h00, 0, STATUS_OK, 16'sd0);
        add_row(REQ_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 0, STATUS_OK, 16'sd0);
        // Highest address and register; response carries the most negative value.
        add_row(REQ_START, 8'hFF, 16'hFFFF, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'hFF, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, FUNC_READ_INPUT, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h02, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h80, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'hAA, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'hBB, 1, STATUS_OK, 16'sh8000);
        // A byte after the report is ignored.
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h00, 0, STATUS_OK, 16'sd0);
        // Lowest address and register; an exception function code in the reply.
        add_row(REQ_START, 8'h00, 16'h0000, 8'hFF, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h84, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h02, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h7F, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'hFF, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'hFF, 16'hFFFF, 8'h00, 1, STATUS_MISMATCH, 16'sd0);
        // Wrong slave in the reply, then a new query drops the exchange.
        add_row(REQ_START, 8'h5A, 16'hA55A, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h5B, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_START, 8'h80, 16'h00FF, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_BYTE, 8'h00, 16'h0000, 8'h80, NO_FIXED, STATUS_OK, 16'sd0);
        add_row(REQ_TICK, 8'h00, 16'h0000, 8'h00, NO_FIXED, STATUS_OK, 16'sd0);
        foreach (directed_rows[i])
            issue(directed_rows[i].rq, directed_rows[i].fixed_n,
                  directed_rows[i].fixed_status, directed_rows[i].fixed_value);
        drain();

        timeout_plan[0] = 16'd1;
        timeout_plan[1] = 16'd0;
        timeout_plan[2] = 16'hFFFF;
        timeout_plan[3] = 16'd3;
        timeout_plan[4] = TIMEOUT_RESET;
        timeout_plan[5] = 16'($urandom_range(4, 12));
        foreach (timeout_plan[p])
        begin
            write_timeout(timeout_plan[p]);
            burst_mode = (p == 3);
            // Hold the output off while queries keep coming, so the command
            // queue fills and the input side stalls.
            if (timeout_plan[p] == 16'hFFFF)
            begin
                hold_off_req = 1'b1;
                while (!hold_active)
                    @(posedge clk);
                repeat (6) send_start(8'($urandom), 16'($urandom));
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_exchange();
            drain();
        end
        burst_mode = 1'b0;

        $display("Run covered %0d input transactions and %0d query frames over %0d timeout settings.",
                 items_sent, frames_sent, settings_used);
        $display("Reports seen: %0d ok, %0d header mismatch, %0d timeout.",
                 reports_ok, reports_mismatch, reports_timeout);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mrirm_pkg.sv
rtl/mrirm_front.sv
rtl/mrirm_queue.sv
rtl/mrirm_back.sv
rtl/modbus_read_input_register_master_top.sv
tb/tb_modbus_read_input_register_master_top.sv
